FILE: rtl/svfd_pkg.sv
// ----------------------------------------------------------------------------
// svfd_pkg
// Types and constants shared by the serial voltage-ID frame decoder.
// ----------------------------------------------------------------------------
package svfd_pkg;

  // Sample and index widths
  localparam int SAMPLE_W   = 8;
  localparam int INDEX_W    = 48;
  localparam int POS_W      = 3;
  localparam int VOLT_W     = 21;

  // Configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = POS_W;
  localparam logic [CFG_IDX_W-1:0] REG_CLOCK_POS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DATA_POS  = 1'd1;
  localparam logic [POS_W-1:0]     CLOCK_POS_RST = 3'd0;
  localparam logic [POS_W-1:0]     DATA_POS_RST  = 3'd1;

  // Bus phase codes
  localparam logic [1:0] PH_WAIT = 2'd0;
  localparam logic [1:0] PH_BYTE = 2'd1;
  localparam logic [1:0] PH_ACK  = 2'd2;

  // Frame status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_LENGTH   = 2'd1;
  localparam logic [1:0] ST_ACK      = 2'd2;
  localparam logic [1:0] ST_PREAMBLE = 2'd3;

  // Frame layout
  localparam logic [3:0] BITS_PER_BYTE  = 4'd8;
  localparam logic [2:0] FRAME_BYTES    = 3'd3;
  localparam logic [2:0] BYTE_COUNT_MAX = 3'd4;
  localparam logic [7:0] PREAMBLE_MASK  = 8'hF8;
  localparam logic [7:0] PREAMBLE_VAL   = 8'hC0;

  // VID to voltage conversion
  localparam logic [7:0]        VID_LIMIT    = 8'hF8;
  localparam logic [VOLT_W-1:0] VOLT_BASE_UV = 21'd1550000;
  localparam logic [VOLT_W-1:0] VOLT_STEP_UV = 21'd6250;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample_bits;
    logic [INDEX_W-1:0]  sample_index;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         frame_status;
    logic [INDEX_W-1:0] start_sample;
    logic               core_select;
    logic               soc_select;
    logic               psi0_low;
    logic [7:0]         vid_code;
    logic               psi1_low;
    logic               telemetry_off;
    logic [2:0]         load_line_trim;
    logic [1:0]         offset_trim;
    logic [VOLT_W-1:0]  voltage_uv;
  } out_item_t;

endpackage

FILE: rtl/serial_vid_frame_decoder.sv
// ----------------------------------------------------------------------------
// serial_vid_frame_decoder
// Decodes serial voltage-ID frames from a stream of oversampled logic samples.
// ----------------------------------------------------------------------------
// One sample request is taken per clock while input ready is high, and all of
// its work (edge detection, bit capture, frame decode) completes in that cycle,
// so the block sustains one sample per cycle until both output stages are full.
// A stop condition registers one frame request into the output register, or
// into the skid stage, which absorbs one frame while the downstream side stalls;
// input ready drops only when both stages are full. Clock and data bit positions
// are set through the configuration port and should be written while the bus is idle.
// ----------------------------------------------------------------------------
module serial_vid_frame_decoder (
  input  logic                                clk,
  input  logic                                rst_n,
  // configuration
  input  logic                                cfg_we,
  input  logic [svfd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [svfd_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  // sample input
  input  logic                                in_valid,
  output logic                                in_ready,
  input  svfd_pkg::in_item_t                  in_data,
  // frame output
  output logic                                out_valid,
  input  logic                                out_ready,
  output svfd_pkg::out_item_t                 out_data
);

  // Configuration registers
  logic [svfd_pkg::POS_W-1:0] clk_pos_r;
  logic [svfd_pkg::POS_W-1:0] dat_pos_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clk_pos_r <= svfd_pkg::CLOCK_POS_RST;
      dat_pos_r <= svfd_pkg::DATA_POS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        svfd_pkg::REG_CLOCK_POS: clk_pos_r <= cfg_wdata;
        svfd_pkg::REG_DATA_POS:  dat_pos_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Decoder state
  logic [1:0]                   phase_r,      phase_nxt;
  logic                         prev_clk_r,   prev_clk_nxt;
  logic                         prev_dat_r,   prev_dat_nxt;
  logic [3:0]                   bits_rem_r,   bits_rem_nxt;
  logic [2:0]                   byte_cnt_r,   byte_cnt_nxt;
  logic [7:0]                   bytes_r [3];
  logic [7:0]                   bytes_nxt [3];
  logic [svfd_pkg::INDEX_W-1:0] start_idx_r,  start_idx_nxt;
  logic                         ack_fault_r,  ack_fault_nxt;

  // Output stages
  logic                  out_valid_r,  out_valid_nxt;
  svfd_pkg::out_item_t   out_data_r,   out_data_nxt;
  logic                  skid_valid_r, skid_valid_nxt;
  svfd_pkg::out_item_t   skid_data_r,  skid_data_nxt;

  logic                  accept;
  logic                  s_clk;
  logic                  s_dat;
  logic                  start_cond;
  logic                  stop_cond;
  logic                  res_valid;
  svfd_pkg::out_item_t   res;
  logic [3:0]            br_load;
  logic [3:0]            br_dec;
  logic [7:0]            vid;
  logic [svfd_pkg::VOLT_W-1:0] volt_step;

  assign in_ready = !skid_valid_r;
  assign accept   = in_valid && in_ready;

  // Pick serial clock and data lines out of the sample
  assign s_clk = in_data.sample_bits[clk_pos_r];
  assign s_dat = in_data.sample_bits[dat_pos_r];

  assign start_cond = s_clk && prev_clk_r && !s_dat && prev_dat_r
                      && (phase_r == svfd_pkg::PH_WAIT);
  assign stop_cond  = s_clk && prev_clk_r && s_dat && !prev_dat_r
                      && (phase_r == svfd_pkg::PH_BYTE);
  assign res_valid  = accept && stop_cond;

  // Bit counter reload and decrement
  assign br_load = ((bits_rem_r == 4'd0) || (bits_rem_r > svfd_pkg::BITS_PER_BYTE))
                   ? svfd_pkg::BITS_PER_BYTE : bits_rem_r;
  assign br_dec  = br_load - 4'd1;

  // Frame decode from the held bytes
  assign vid       = {bytes_r[1][6:0], bytes_r[2][7]};
  assign volt_step = svfd_pkg::VOLT_W'(vid) * svfd_pkg::VOLT_STEP_UV;

  always_comb begin
    res.start_sample   = start_idx_r;
    res.core_select    = bytes_r[0][2];
    res.soc_select     = bytes_r[0][1];
    res.psi0_low       = bytes_r[1][7];
    res.vid_code       = vid;
    res.psi1_low       = bytes_r[2][6];
    res.telemetry_off  = bytes_r[2][5];
    res.load_line_trim = bytes_r[2][4:2];
    res.offset_trim    = bytes_r[2][1:0];
    res.voltage_uv     = (vid < svfd_pkg::VID_LIMIT)
                         ? (svfd_pkg::VOLT_BASE_UV - volt_step) : '0;
    if (byte_cnt_r != svfd_pkg::FRAME_BYTES) begin
      res.frame_status = svfd_pkg::ST_LENGTH;
    end else if (ack_fault_r) begin
      res.frame_status = svfd_pkg::ST_ACK;
    end else if (((bytes_r[0] & svfd_pkg::PREAMBLE_MASK) != svfd_pkg::PREAMBLE_VAL)
                 || bytes_r[0][0]) begin
      res.frame_status = svfd_pkg::ST_PREAMBLE;
    end else begin
      res.frame_status = svfd_pkg::ST_OK;
    end
  end

  // Next-state logic for one accepted sample
  always_comb begin
    phase_nxt     = phase_r;
    prev_clk_nxt  = prev_clk_r;
    prev_dat_nxt  = prev_dat_r;
    bits_rem_nxt  = bits_rem_r;
    byte_cnt_nxt  = byte_cnt_r;
    bytes_nxt     = bytes_r;
    start_idx_nxt = start_idx_r;
    ack_fault_nxt = ack_fault_r;
    if (accept) begin
      prev_clk_nxt = s_clk;
      prev_dat_nxt = s_dat;
      if (start_cond) begin
        phase_nxt     = svfd_pkg::PH_BYTE;
        byte_cnt_nxt  = '0;
        bits_rem_nxt  = svfd_pkg::BITS_PER_BYTE;
        start_idx_nxt = in_data.sample_index;
        bytes_nxt     = '{default: '0};
        ack_fault_nxt = 1'b0;
      end else if (stop_cond) begin
        phase_nxt = svfd_pkg::PH_WAIT;
      end else if (s_clk && !prev_clk_r && (phase_r != svfd_pkg::PH_WAIT)) begin
        // rising clock edge inside a frame
        unique case (phase_r)
          svfd_pkg::PH_BYTE: begin
            bits_rem_nxt = br_dec;
            if ((byte_cnt_r < svfd_pkg::FRAME_BYTES) && s_dat) begin
              bytes_nxt[byte_cnt_r[1:0]][br_dec[2:0]] = 1'b1;
            end
            if (br_dec == 4'd0) begin
              phase_nxt = svfd_pkg::PH_ACK;
            end
          end
          svfd_pkg::PH_ACK: begin
            if (s_dat) begin
              ack_fault_nxt = 1'b1;
            end
            if (byte_cnt_r < svfd_pkg::BYTE_COUNT_MAX) begin
              byte_cnt_nxt = byte_cnt_r + 3'd1;
            end
            phase_nxt    = svfd_pkg::PH_BYTE;
            bits_rem_nxt = svfd_pkg::BITS_PER_BYTE;
          end
          default: begin
            phase_nxt = svfd_pkg::PH_WAIT;
          end
        endcase
      end
    end
  end

  // Output register plus one skid stage
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    skid_valid_nxt = skid_valid_r;
    skid_data_nxt  = skid_data_r;
    if (!out_valid_r || out_ready) begin
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end else if (res_valid) begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = res;
      end else begin
        out_valid_nxt = 1'b0;
      end
    end else if (res_valid) begin
      skid_valid_nxt = 1'b1;
      skid_data_nxt  = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= svfd_pkg::PH_WAIT;
      prev_clk_r   <= 1'b1;
      prev_dat_r   <= 1'b0;
      bits_rem_r   <= svfd_pkg::BITS_PER_BYTE;
      byte_cnt_r   <= '0;
      bytes_r      <= '{default: '0};
      start_idx_r  <= '0;
      ack_fault_r  <= 1'b0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      phase_r      <= phase_nxt;
      prev_clk_r   <= prev_clk_nxt;
      prev_dat_r   <= prev_dat_nxt;
      bits_rem_r   <= bits_rem_nxt;
      byte_cnt_r   <= byte_cnt_nxt;
      bytes_r      <= bytes_nxt;
      start_idx_r  <= start_idx_nxt;
      ack_fault_r  <= ack_fault_nxt;
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  // Payload registers, no reset
  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
